### design/dad_pkg.sv
// Shared types and constants of the detection anchor decoder.
package dad_pkg;

    localparam int          SIG_SPAN_BITS = 12;
    localparam logic [16:0] PROB_ONE      = 17'd65536;
    localparam logic [11:0] COORD_LIMIT   = 12'd4095;
    localparam logic [12:0] EXTENT_MAX    = 13'd4096;

    localparam logic [6:0]  RST_CLASS_COUNT    = 7'd1;
    localparam logic [16:0] RST_CONF_THRESHOLD = 17'd16384;
    localparam logic [10:0] RST_PAD            = 11'd0;
    localparam logic [23:0] RST_INV_SCALE      = 24'd65536;
    localparam logic [12:0] RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd480;

    typedef enum logic [2:0] {
        REG_CLASS_COUNT    = 3'd0,
        REG_CONF_THRESHOLD = 3'd1,
        REG_PAD_X          = 3'd2,
        REG_PAD_Y          = 3'd3,
        REG_INV_SCALE      = 3'd4,
        REG_IMAGE_WIDTH    = 3'd5,
        REG_IMAGE_HEIGHT   = 3'd6
    } reg_index_e;

    typedef struct packed {
        logic [6:0]  class_count;
        logic [16:0] conf_threshold;
        logic [10:0] pad_x;
        logic [10:0] pad_y;
        logic [23:0] inv_scale;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [16:0]       prob;
        logic signed [6:0] cls;
    } anchor_sum_t;

    typedef struct packed {
        logic              tail_valid;
        logic              emit;
    } map_status_t;

    // last member lands in the lowest bits
    typedef struct packed {
        logic [16:0] confidence;
        logic [6:0]  class_index;
        logic [11:0] box_height;
        logic [11:0] box_width;
        logic [11:0] box_top;
        logic [11:0] box_left;
    } res_t;

endpackage

### design/dad_sig_rom.sv
// Sigmoid lookup ROM with registered read, contents built at elaboration.
module dad_sig_rom #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] addr,
    output logic [16:0]   data
);

    typedef logic [16:0] tab_t [DEPTH];

    // shift-subtract quotient, evaluated only while the table is built
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic tab_t build_table();
        tab_t             t;
        longint unsigned  u;
        longint unsigned  term;
        longint unsigned  s;
        longint unsigned  y;
        longint unsigned  d;
        for (int k = 0; k < DEPTH; k++)
        begin
            u    = div_u64(longint'(k) << 29, longint'(DEPTH));
            term = 64'd1 << 31;
            s    = 64'd1 << 31;
            for (int n = 1; n <= 12; n++)
            begin
                term = div_u64((term * u) >> 31, longint'(n));
                if (n[0])
                    s = s - term;
                else
                    s = s + term;
            end
            y = s;
            for (int n = 0; n < 6; n++)
                y = (y * y + (64'd1 << 30)) >> 31;
            d    = (64'd1 << 31) + y;
            t[k] = 17'(div_u64((64'd65536 << 31) + (d >> 1), d));
        end
        return t;
    endfunction

    localparam tab_t SIG_TABLE = build_table();

    logic [16:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SIG_TABLE[addr];
    end

    assign data = data_reg;

endmodule

### design/dad_score.sv
// Score to probability conversion, running argmax and box channel capture.
module dad_score #(
    parameter int VALUE_BITS          = 24,
    parameter int SIGMOID_TABLE_DEPTH = 1024,
    parameter int MAX_CLASSES         = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  logic                         in_last,
    input  logic [6:0]                   in_count,
    input  logic [6:0]                   class_count,
    output dad_pkg::anchor_sum_t         sum,
    output logic signed [VALUE_BITS-1:0] box_field [4]
);
    import dad_pkg::*;

    localparam int AW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int SW = SIG_SPAN_BITS + $clog2(SIGMOID_TABLE_DEPTH + 1);

    logic [VALUE_BITS-1:0] raw_bits;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  sat;
    logic                  direct;
    logic [SW-1:0]         scaled;
    logic [AW-1:0]         addr;
    logic [16:0]           rom_data;

    assign raw_bits = in_value;
    assign neg      = in_value[VALUE_BITS-1];
    assign mag      = neg ? (~raw_bits + VALUE_BITS'(1)) : raw_bits;
    assign sat      = |mag[VALUE_BITS-1:SIG_SPAN_BITS];
    assign direct   = !neg && (mag[VALUE_BITS-1:9] == '0) && (mag[8:0] <= 9'd256);
    assign scaled   = SW'(mag[SIG_SPAN_BITS-1:0]) * SW'(SIGMOID_TABLE_DEPTH);
    assign addr     = scaled[SIG_SPAN_BITS +: AW];

    dad_sig_rom #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .en   (advance),
        .addr (addr),
        .data (rom_data)
    );

    logic                         rd_valid_reg;
    logic                         rd_last_reg;
    logic [6:0]                   rd_count_reg;
    logic signed [VALUE_BITS-1:0] rd_value_reg;
    logic                         rd_direct_reg;
    logic                         rd_sat_reg;
    logic                         rd_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else if (advance)
            rd_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_last_reg   <= in_last;
            rd_count_reg  <= in_count;
            rd_value_reg  <= in_value;
            rd_direct_reg <= direct;
            rd_sat_reg    <= sat;
            rd_neg_reg    <= neg;
        end
    end

    logic [16:0]                  table_p;
    logic [16:0]                  sig_p;
    logic [16:0]                  prob;
    logic [6:0]                   lim;
    logic [6:0]                   cls_idx;
    logic                         is_box;
    logic                         is_cls;
    logic                         upd;
    logic [16:0]                  best_prob_reg;
    logic signed [6:0]            best_class_reg;
    logic signed [VALUE_BITS-1:0] box_reg [4];
    logic [16:0]                  best_prob_next;
    logic signed [6:0]            best_class_next;
    logic signed [VALUE_BITS-1:0] box_next [4];
    logic                         sum_valid_reg;
    logic [16:0]                  sum_prob_reg;
    logic signed [6:0]            sum_cls_reg;
    logic signed [VALUE_BITS-1:0] snap_reg [4];

    assign table_p = rd_sat_reg ? PROB_ONE : rom_data;
    assign sig_p   = rd_neg_reg ? (PROB_ONE - table_p) : table_p;
    assign prob    = rd_direct_reg ? {rd_value_reg[8:0], 8'h00} : sig_p;

    assign lim     = (class_count == 7'd0 || class_count > 7'(MAX_CLASSES))
                     ? 7'(MAX_CLASSES) : class_count;
    assign is_box  = rd_count_reg < 7'd4;
    assign cls_idx = rd_count_reg - 7'd4;
    assign is_cls  = !is_box && (cls_idx < lim);
    assign upd     = is_cls && (prob > best_prob_reg);

    always_comb
    begin
        best_prob_next  = upd ? prob : best_prob_reg;
        best_class_next = upd ? $signed(cls_idx) : best_class_reg;
        for (int i = 0; i < 4; i++)
            box_next[i] = (is_box && rd_count_reg[1:0] == 2'(i)) ? rd_value_reg : box_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_prob_reg  <= '0;
            best_class_reg <= -7'sd1;
            for (int i = 0; i < 4; i++)
                box_reg[i] <= '0;
            sum_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= rd_valid_reg && rd_last_reg;
            if (rd_valid_reg)
            begin
                if (rd_last_reg)
                begin
                    best_prob_reg  <= '0;
                    best_class_reg <= -7'sd1;
                    for (int i = 0; i < 4; i++)
                        box_reg[i] <= '0;
                end
                else
                begin
                    best_prob_reg  <= best_prob_next;
                    best_class_reg <= best_class_next;
                    box_reg        <= box_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rd_valid_reg && rd_last_reg)
        begin
            sum_prob_reg <= best_prob_next;
            sum_cls_reg  <= best_class_next;
            snap_reg     <= box_next;
        end
    end

    assign sum       = '{valid: sum_valid_reg, prob: sum_prob_reg, cls: sum_cls_reg};
    assign box_field = snap_reg;

endmodule

### design/dad_box_map.sv
// Letterbox inversion, clamping and rounding of the anchor's box corners.
module dad_box_map #(
    parameter int VALUE_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  dad_pkg::cfg_t                cfg,
    input  dad_pkg::anchor_sum_t         sum,
    input  logic signed [VALUE_BITS-1:0] box_field [4],
    output dad_pkg::map_status_t         status,
    output dad_pkg::res_t                result
);
    import dad_pkg::*;

    localparam int DW = ((VALUE_BITS + 2 > 21) ? VALUE_BITS + 2 : 21) + 1;
    localparam int PW = DW + 25;

    logic signed [DW-1:0] cx2;
    logic signed [DW-1:0] cy2;
    logic signed [DW-1:0] w_e;
    logic signed [DW-1:0] h_e;
    logic signed [DW-1:0] padx_q9;
    logic signed [DW-1:0] pady_q9;
    logic signed [DW-1:0] diff_next [4];

    assign cx2     = DW'(box_field[0]) <<< 1;
    assign cy2     = DW'(box_field[1]) <<< 1;
    assign w_e     = DW'(box_field[2]);
    assign h_e     = DW'(box_field[3]);
    assign padx_q9 = DW'($signed({1'b0, cfg.pad_x, 9'b0}));
    assign pady_q9 = DW'($signed({1'b0, cfg.pad_y, 9'b0}));

    always_comb
    begin
        diff_next[0] = cx2 - w_e - padx_q9;
        diff_next[1] = cx2 + w_e - padx_q9;
        diff_next[2] = cy2 - h_e - pady_q9;
        diff_next[3] = cy2 + h_e - pady_q9;
    end

    logic                 diff_valid_reg;
    logic                 diff_pass_reg;
    logic [16:0]          diff_prob_reg;
    logic signed [6:0]    diff_cls_reg;
    logic signed [DW-1:0] diff_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            diff_valid_reg <= 1'b0;
        else if (advance)
            diff_valid_reg <= sum.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_pass_reg <= sum.prob >= cfg.conf_threshold;
            diff_prob_reg <= sum.prob;
            diff_cls_reg  <= sum.cls;
            diff_reg      <= diff_next;
        end
    end

    logic signed [24:0]   scale_s;
    logic signed [PW-1:0] prod_next [4];

    assign scale_s = $signed({1'b0, cfg.inv_scale});

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            prod_next[i] = PW'(diff_reg[i]) * PW'(scale_s);
    end

    logic                 prod_valid_reg;
    logic                 prod_pass_reg;
    logic [16:0]          prod_prob_reg;
    logic signed [6:0]    prod_cls_reg;
    logic signed [PW-1:0] prod_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (advance)
            prod_valid_reg <= diff_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_pass_reg <= diff_pass_reg;
            prod_prob_reg <= diff_prob_reg;
            prod_cls_reg  <= diff_cls_reg;
            prod_reg      <= prod_next;
        end
    end

    function automatic logic [11:0] axis_limit(input logic [12:0] extent);
        logic [12:0] lim;
        lim = extent - 13'd1;
        if (extent == 13'd0)
            return 12'd0;
        else if (extent > EXTENT_MAX)
            return COORD_LIMIT;
        else
            return lim[11:0];
    endfunction

    function automatic logic [11:0] corner(input logic signed [PW-1:0] v,
                                           input logic [11:0] lim);
        logic [PW:0]    rounded;
        logic [PW-25:0] px;
        rounded = {1'b0, v} + (PW+1)'(1 << 24);
        px      = rounded[PW:25];
        if (v[PW-1])
            return 12'd0;
        else if (px > (PW-24)'(lim))
            return lim;
        else
            return px[11:0];
    endfunction

    logic [11:0] lim_x;
    logic [11:0] lim_y;
    logic [11:0] el;
    logic [11:0] er;
    logic [11:0] et;
    logic [11:0] eb;

    assign lim_x = axis_limit(cfg.image_width);
    assign lim_y = axis_limit(cfg.image_height);
    assign el    = corner(prod_reg[0], lim_x);
    assign er    = corner(prod_reg[1], lim_x);
    assign et    = corner(prod_reg[2], lim_y);
    assign eb    = corner(prod_reg[3], lim_y);

    assign status.tail_valid = prod_valid_reg;
    assign status.emit       = prod_valid_reg && prod_pass_reg && (er > el) && (eb > et);

    assign result.box_left    = el;
    assign result.box_top     = et;
    assign result.box_width   = er - el;
    assign result.box_height  = eb - et;
    assign result.class_index = prod_cls_reg;
    assign result.confidence  = prod_prob_reg;

endmodule

### design/detection_anchor_decoder_core.sv
// Top level of the detection anchor decoder: config port, pipeline and result register.
//
//   channel   direction  content
//   s_*       in         one channel value per item, s_tlast on the anchor's last channel
//   m_*       out        one decoded box per passing anchor
//   APB       in/out     seven configuration registers at 4*index
//
// One item is accepted per cycle unless the pipeline stalls.
// The sigmoid ROM read and the four corner multipliers each take a pipeline stage.
// Reset clears the channel counter, the argmax state and all stage valid bits.
// The pipeline stalls only while an anchor end sits in the last stage and the
// result register still holds a box that the sink has not taken.
module detection_anchor_decoder_core #(
    parameter int VALUE_BITS          = 24,
    parameter int SIGMOID_TABLE_DEPTH = 1024,
    parameter int MAX_CLASSES         = 64,
    localparam int TDATA_BITS         = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // channel_value
    input  logic                  s_tlast,   // anchor_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,   // box_left, box_top, box_width, box_height,
                                             // class_index, confidence
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import dad_pkg::*;

    cfg_t cfg_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.class_count    <= RST_CLASS_COUNT;
            cfg_reg.conf_threshold <= RST_CONF_THRESHOLD;
            cfg_reg.pad_x          <= RST_PAD;
            cfg_reg.pad_y          <= RST_PAD;
            cfg_reg.inv_scale      <= RST_INV_SCALE;
            cfg_reg.image_width    <= RST_IMAGE_WIDTH;
            cfg_reg.image_height   <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_e'(paddr[4:2]))
                REG_CLASS_COUNT:    cfg_reg.class_count    <= pwdata[6:0];
                REG_CONF_THRESHOLD: cfg_reg.conf_threshold <= pwdata[16:0];
                REG_PAD_X:          cfg_reg.pad_x          <= pwdata[10:0];
                REG_PAD_Y:          cfg_reg.pad_y          <= pwdata[10:0];
                REG_INV_SCALE:      cfg_reg.inv_scale      <= pwdata[23:0];
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= pwdata[12:0];
                REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= pwdata[12:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_e'(paddr[4:2]))
            REG_CLASS_COUNT:    prdata = 32'(cfg_reg.class_count);
            REG_CONF_THRESHOLD: prdata = 32'(cfg_reg.conf_threshold);
            REG_PAD_X:          prdata = 32'(cfg_reg.pad_x);
            REG_PAD_Y:          prdata = 32'(cfg_reg.pad_y);
            REG_INV_SCALE:      prdata = 32'(cfg_reg.inv_scale);
            REG_IMAGE_WIDTH:    prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:   prdata = 32'(cfg_reg.image_height);
            default:            prdata = 32'd0;
        endcase
    end

    map_status_t status;
    res_t        result;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        advance;
    logic        accept;

    assign advance  = !(status.tail_valid && out_valid_reg && !m_tready);
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    logic                         in_valid_reg;
    logic signed [VALUE_BITS-1:0] in_value_reg;
    logic                         in_last_reg;
    logic [6:0]                   in_count_reg;
    logic [6:0]                   cnt_reg;
    logic [6:0]                   cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (s_tlast)
                cnt_next = 7'd0;
            else if (cnt_reg != 7'd127)
                cnt_next = cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= 7'd0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (advance)
                in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_value_reg <= $signed(s_tdata[VALUE_BITS-1:0]);
            in_last_reg  <= s_tlast;
            in_count_reg <= cnt_reg;
        end
    end

    anchor_sum_t                  sum;
    logic signed [VALUE_BITS-1:0] box_field [4];

    dad_score #(
        .VALUE_BITS          (VALUE_BITS),
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH),
        .MAX_CLASSES         (MAX_CLASSES)
    ) u_score (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid_reg),
        .in_value    (in_value_reg),
        .in_last     (in_last_reg),
        .in_count    (in_count_reg),
        .class_count (cfg_reg.class_count),
        .sum         (sum),
        .box_field   (box_field)
    );

    dad_box_map #(
        .VALUE_BITS (VALUE_BITS)
    ) u_box_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .sum       (sum),
        .box_field (box_field),
        .status    (status),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= (advance && status.emit) || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk)
    begin
        if (advance && status.emit)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_no_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:24] != 12'd0) && (m_tdata[47:36] != 12'd0))
        else $error("empty box presented");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[71:55] <= PROB_ONE))
        else $error("confidence above one");

    a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (status.tail_valid && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while tail result is blocked");

    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (cnt_reg == 7'd0))
        else $error("channel counter not cleared at anchor end");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> !(status.emit && !advance) || m_tvalid)
        else $error("pending result lost");

endmodule

### verif/testbench.sv
// Self-checking testbench of detection_anchor_decoder_core: channel stream in, decoded boxes out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dad_pkg::*;

    localparam int  SIG_DEPTH     = 1024;
    localparam int  CLASS_MAX     = 64;
    localparam int  PHASE_ITEMS   = 220;
    localparam int  RANDOM_PHASES = 8;
    localparam int  SETTLE        = 16;
    localparam int  CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [23:0] value;
        logic        last;
        logic        typed;
        logic        hit;
        res_t        box;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // channel_value
    logic        s_tlast  = 1'b0; // anchor_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // box_left, box_top, box_width, box_height,
                                  // class_index, confidence
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    detection_anchor_decoder_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    int unsigned sig_lut [SIG_DEPTH];

    longint cfg_classes = longint'(RST_CLASS_COUNT);
    longint cfg_thresh  = longint'(RST_CONF_THRESHOLD);
    longint cfg_pad_x   = longint'(RST_PAD);
    longint cfg_pad_y   = longint'(RST_PAD);
    longint cfg_inv     = longint'(RST_INV_SCALE);
    longint cfg_width   = longint'(RST_IMAGE_WIDTH);
    longint cfg_height  = longint'(RST_IMAGE_HEIGHT);

    int     ch_count = 0;
    longint box_raw [4] = '{0, 0, 0, 0};
    longint best_p   = 0;
    longint best_c   = -1;

    res_t      expected_boxes [$];
    stim_row_t stim_rows [$];

    int  fail_count     = 0;
    int  items_sent     = 0;
    int  anchors_sent   = 0;
    int  boxes_expected = 0;
    int  boxes_checked  = 0;
    int  settings_used  = 1;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  bursty         = 1'b1;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < 40)
            $display("mismatch %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        fail_count++;
    endtask

    function automatic longint score_prob(input longint raw);
        longint mag;
        longint p;
        if (raw >= 0 && raw <= 256)
            return raw * 256;
        mag = (raw < 0) ? -raw : raw;
        if (mag >= 4096)
            p = longint'(PROB_ONE);
        else
            p = longint'(sig_lut[(mag * SIG_DEPTH) / 4096]);
        return (raw < 0) ? longint'(PROB_ONE) - p : p;
    endfunction

    function automatic longint map_corner(input longint q9, input longint pad,
                                          input longint extent);
        longint v;
        longint px;
        longint lim;
        lim = (extent == 0) ? 0 : extent - 1;
        if (lim > longint'(COORD_LIMIT))
            lim = longint'(COORD_LIMIT);
        v = (q9 - pad * 512) * cfg_inv;
        if (v < 0)
            return 0;
        px = (v + (longint'(1) << 24)) >> 25;
        return (px > lim) ? lim : px;
    endfunction

    task automatic decode_channel(input logic [23:0] value, input bit last,
                                  output bit hit, output res_t box);
        longint raw;
        longint lim;
        longint p;
        longint el;
        longint er;
        longint et;
        longint eb;
        raw = longint'($signed(value));
        hit = 1'b0;
        box = '0;
        if (ch_count < 4)
            box_raw[ch_count] = raw;
        else
        begin
            lim = (cfg_classes == 0 || cfg_classes > CLASS_MAX) ? CLASS_MAX : cfg_classes;
            if (ch_count - 4 < lim)
            begin
                p = score_prob(raw);
                if (p > best_p)
                begin
                    best_p = p;
                    best_c = longint'(ch_count - 4);
                end
            end
        end
        if (!last)
        begin
            if (ch_count < 127)
                ch_count++;
        end
        else
        begin
            el = map_corner(2 * box_raw[0] - box_raw[2], cfg_pad_x, cfg_width);
            er = map_corner(2 * box_raw[0] + box_raw[2], cfg_pad_x, cfg_width);
            et = map_corner(2 * box_raw[1] - box_raw[3], cfg_pad_y, cfg_height);
            eb = map_corner(2 * box_raw[1] + box_raw[3], cfg_pad_y, cfg_height);
            if (best_p >= cfg_thresh && er > el && eb > et)
            begin
                hit = 1'b1;
                box.box_left    = el[11:0];
                box.box_top     = et[11:0];
                box.box_width   = 12'(er - el);
                box.box_height  = 12'(eb - et);
                box.class_index = best_c[6:0];
                box.confidence  = best_p[16:0];
            end
            ch_count = 0;
            box_raw  = '{0, 0, 0, 0};
            best_p   = 0;
            best_c   = -1;
            anchors_sent++;
        end
    endtask

    task automatic drive_item(input logic [23:0] value, input bit last, input bit typed,
                              input bit typed_hit, input res_t typed_box);
        bit   hit;
        res_t box;
        if (bursty && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        decode_channel(value, last, hit, box);
        if (typed)
        begin
            hit = typed_hit;
            box = typed_box;
        end
        if (hit)
        begin
            expected_boxes.insert(expected_boxes.size(), box);
            boxes_expected++;
        end
    endtask

    task automatic add_row(input logic [23:0] value, input bit last, input bit typed,
                           input bit hit, input res_t box);
        stim_row_t row;
        row.value = value;
        row.last  = last;
        row.typed = typed;
        row.hit   = hit;
        row.box   = box;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    task automatic write_reg(input reg_index_e idx, input longint value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value[31:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_CLASS_COUNT:    cfg_classes = value & 'h7F;
            REG_CONF_THRESHOLD: cfg_thresh  = value & 'h1FFFF;
            REG_PAD_X:          cfg_pad_x   = value & 'h7FF;
            REG_PAD_Y:          cfg_pad_y   = value & 'h7FF;
            REG_INV_SCALE:      cfg_inv     = value & 'hFFFFFF;
            REG_IMAGE_WIDTH:    cfg_width   = value & 'h1FFF;
            REG_IMAGE_HEIGHT:   cfg_height  = value & 'h1FFF;
            default: ;
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [23:0] chan_value(input int ch);
        longint v;
        if (ch < 4 && $urandom_range(0, 9) == 0)
            return 24'($urandom);
        case (ch)
            0:       v = (cfg_pad_x + $urandom_range(0, 700)) * 256 + $urandom_range(0, 255);
            1:       v = (cfg_pad_y + $urandom_range(0, 700)) * 256 + $urandom_range(0, 255);
            2, 3:    v = $urandom_range(0, 400) * 256 + $urandom_range(0, 255);
            default:
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = longint'($urandom_range(0, 256));
                    4, 5:       v = longint'($urandom_range(0, 8400)) - 4200;
                    6:          v = longint'($urandom);
                    7:
                        case ($urandom_range(0, 8))
                            0:       v = 0;
                            1:       v = 256;
                            2:       v = 257;
                            3:       v = 4095;
                            4:       v = 4096;
                            5:       v = -4096;
                            6:       v = -4095;
                            7:       v = -1;
                            default: v = -257;
                        endcase
                    default:    v = -longint'($urandom_range(1, 4095));
                endcase
        endcase
        return v[23:0];
    endfunction

    task automatic gen_anchor;
        int shape;
        int span;
        int len;
        bit noise;
        bit last;
        span  = 4 + int'((cfg_classes == 0 || cfg_classes > CLASS_MAX) ? CLASS_MAX
                                                                          : cfg_classes);
        shape = $urandom_range(0, 99);
        noise = 1'b0;
        if (shape < 75)
            len = span;
        else if (shape < 85)
            len = $urandom_range(1, span - 1);
        else if (shape < 95)
            len = span + $urandom_range(1, 4);
        else if (shape < 97)
            len = 130;
        else
        begin
            len   = $urandom_range(1, 12);
            noise = 1'b1;
        end
        for (int ch = 0; ch < len; ch++)
        begin
            last = (ch == len - 1) || (noise && $urandom_range(0, 3) == 0);
            drive_item(noise ? 24'($urandom) : chan_value(ch), last, 1'b0, 1'b0, '0);
        end
    endtask

    task automatic check_box(input res_t got);
        res_t want;
        if (expected_boxes.size() == 0)
        begin
            report_mismatch("box with none pending, box_left", longint'(got.box_left), 0);
            return;
        end
        want = expected_boxes.pop_front();
        boxes_checked++;
        if (got.box_left !== want.box_left)
            report_mismatch("box_left", longint'(got.box_left), longint'(want.box_left));
        if (got.box_top !== want.box_top)
            report_mismatch("box_top", longint'(got.box_top), longint'(want.box_top));
        if (got.box_width !== want.box_width)
            report_mismatch("box_width", longint'(got.box_width), longint'(want.box_width));
        if (got.box_height !== want.box_height)
            report_mismatch("box_height", longint'(got.box_height),
                            longint'(want.box_height));
        if (got.class_index !== want.class_index)
            report_mismatch("class_index", longint'(got.class_index),
                            longint'(want.class_index));
        if (got.confidence !== want.confidence)
            report_mismatch("confidence", longint'(got.confidence),
                            longint'(want.confidence));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_box(res_t'(m_tdata));
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (bursty && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        longint unsigned u;
        longint unsigned term;
        longint unsigned s;
        longint unsigned y;
        longint unsigned d;
        res_t   ref_box;
        res_t   no_box;
        int     phase;
        longint cc;
        longint thr;
        longint px;
        longint py;
        longint inv;
        longint wid;
        longint hgt;

        for (int k = 0; k < SIG_DEPTH; k++)
        begin
            u    = (longint'(k) << 29) / SIG_DEPTH;
            term = 64'd1 << 31;
            s    = 64'd1 << 31;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * u) >> 31) / n;
                if (n % 2 == 1)
                    s = s - term;
                else
                    s = s + term;
            end
            y = s;
            repeat (6) y = (y * y + (64'd1 << 30)) >> 31;
            d = (64'd1 << 31) + y;
            sig_lut[k] = 32'(((64'd65536 << 31) + d / 2) / d);
        end

        // 100,50 center, 40x20 size, score exactly one at unit scale
        ref_box = {17'd65536, 7'd0, 12'd20, 12'd40, 12'd40, 12'd80};
        no_box  = '0;
        add_row(24'd25600, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd12800, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd10240, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd5120,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd256,   1'b1, 1'b1, 1'b1, ref_box);
        // extreme values, zero-size box
        add_row(24'h7FFFFF, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'h800000, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'h000000, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'h000000, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'h7FFFFF, 1'b1, 1'b1, 1'b0, no_box);
        // one-channel anchor
        add_row(24'h000000, 1'b1, 1'b1, 1'b0, no_box);
        // most negative score: probability zero
        add_row(24'd25600,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd12800,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd10240,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd5120,   1'b0, 1'b0, 1'b0, no_box);
        add_row(24'h800000, 1'b1, 1'b1, 1'b0, no_box);
        // sigmoid score plus channels past the class count
        add_row(24'd25600,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd12800,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd10240,  1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd5120,   1'b0, 1'b0, 1'b0, no_box);
        add_row(24'hFFFFFF, 1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd256,    1'b0, 1'b0, 1'b0, no_box);
        add_row(24'd257,    1'b1, 1'b0, 1'b0, no_box);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            drive_item(stim_rows[i].value, stim_rows[i].last, stim_rows[i].typed,
                       stim_rows[i].hit, stim_rows[i].box);
        drain();

        phase = 0;
        while (phase < RANDOM_PHASES)
        begin
            cc  = longint'($urandom_range(1, 8));
            thr = longint'($urandom_range(0, 50000));
            px  = longint'($urandom_range(0, 200));
            py  = longint'($urandom_range(0, 200));
            inv = longint'($urandom_range(16384, 262144));
            wid = longint'($urandom_range(64, 2000));
            hgt = longint'($urandom_range(64, 2000));
            case (phase)
                0:
                begin
                    cc  = 0;
                    thr = 0;
                    px  = 0;
                    py  = 0;
                    inv = longint'(RST_INV_SCALE);
                    wid = longint'(EXTENT_MAX);
                    hgt = longint'(EXTENT_MAX);
                end
                1:
                begin
                    cc  = 127;
                    thr = longint'(PROB_ONE);
                    px  = 2047;
                    py  = 2047;
                    inv = 'hFFFFFF;
                    wid = 'h1FFF;
                    hgt = 'h1FFF;
                end
                2: thr = 'h1FFFF;
                3:
                begin
                    thr = 0;
                    wid = 0;
                    hgt = 0;
                end
                4:
                begin
                    thr = 0;
                    inv = 0;
                end
                5: cc = CLASS_MAX;
                default: ;
            endcase
            write_reg(REG_CLASS_COUNT, cc);
            write_reg(REG_CONF_THRESHOLD, thr);
            write_reg(REG_PAD_X, px);
            write_reg(REG_PAD_Y, py);
            write_reg(REG_INV_SCALE, inv);
            write_reg(REG_IMAGE_WIDTH, wid);
            write_reg(REG_IMAGE_HEIGHT, hgt);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            settings_used++;
            bursty = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            begin
                int start;
                start = items_sent;
                while (items_sent - start < PHASE_ITEMS)
                    gen_anchor();
            end
            drain();
            phase++;
        end

        $display("Covered %0d channel items in %0d anchors over %0d register settings.",
                 items_sent, anchors_sent, settings_used);
        $display("Checked %0d decoded boxes, %0d mismatches.", boxes_checked, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/dad_pkg.sv
design/dad_sig_rom.sv
design/dad_score.sv
design/dad_box_map.sv
design/detection_anchor_decoder_core.sv
verif/testbench.sv
